[design/fbca_pkg.sv]
// Shared types, codes and widths for the FAT block chain allocator.
package fbca_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;

    localparam int CMD_W     = 2;
    localparam int BYTES_W   = 24;
    localparam int BLOCK_W   = 12;
    localparam int BB_W      = 16;
    localparam int CNT_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int NUM_W     = BYTES_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 1'b1;

    localparam logic [BB_W-1:0]  BLOCK_BYTES_RST  = 16'd1024;
    localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

    typedef enum logic [3:0] {
        FS_CLEAR,
        FS_IDLE,
        FS_DIV,
        FS_DIV_CHECK,
        FS_ALLOC_SCAN,
        FS_ALLOC_END,
        FS_FREE_RD,
        FS_FREE_WB,
        FS_NEXT_RD,
        FS_NEXT_WB,
        FS_RECOUNT,
        FS_RESP
    } fbca_state_t;

endpackage

[design/fbca_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module fbca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/fat_block_chain_allocator.sv]
// Top level of the FAT block chain allocator: bitmap and link table in one RAM.
//
// Input beats on s_*: tuser carries the command and the chain-end flag of the
// block field; tdata carries the byte count and the block. Each beat yields
// exactly one result beat on m_*: status, first or next block, its end flag
// and the free count left. Registers are written through cfg_we/cfg_index/
// cfg_wdata (0 block_bytes, 1 total_blocks), one write per cycle.
// One command is in work at a time; s_tready is high only between commands.
// Steps per command, from accept to result beat:
//   allocate: the bit-serial ceiling divider and the space check, then the
//             first-fit scan and the chain end; a request that takes nothing
//             goes from the space check straight to the result.
//   free:     a RAM read and a write-back for each block of the chain.
//   next:     a link read.  Out-of-range, chain-end, others: straight to result.
// Writing total_blocks recounts the free bits below the new n, holding s_tready
// low. After reset a clearing pass over all MAX_BLOCKS entries marks every block
// free and every link as chain end; s_tready stays low meanwhile.
// A finished result sits in an output register; a stalled receiver holds it
// and the next command finishes only once that register is taken.
module fat_block_chain_allocator #(
    parameter int MAX_BLOCKS = fbca_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // byte_count[23:0], block[35:24], zero pad [39:36]
    input  logic [fbca_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[1:0], block_is_end[2]
    input  logic [fbca_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_block[11:0], free_count[24:12], zero pad [31:25]
    output logic [fbca_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0], result_is_end[2]
    output logic [fbca_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                             cfg_we,
    input  logic [fbca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbca_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fbca_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int LW = AW + 1;
    localparam int WW = LW + 1;
    localparam int PAD_W = M_TDATA_W - CNT_W - BLOCK_W;
    localparam logic [LW-1:0] LINK_END = LW'(MAX_BLOCKS);
    localparam logic [LW-1:0] CLEAR_LAST = LW'(MAX_BLOCKS - 1);

    fbca_state_t state_reg, state_next;

    logic [BB_W-1:0]      block_bytes_reg;
    logic [CNT_W-1:0]     total_blocks_reg;
    logic                 recount_pend_reg, recount_pend_next;
    logic [CNT_W-1:0]     free_reg, free_next;
    logic [LW-1:0]        scan_reg, scan_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]     got_reg, got_next;
    logic [CNT_W-1:0]     need_reg, need_next;
    logic [AW-1:0]        first_reg, first_next;
    logic [AW-1:0]        last_reg, last_next;
    logic                 have_last_reg, have_last_next;
    logic [AW-1:0]        cur_reg, cur_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_W-1:0]     div_num_reg, div_num_next;
    logic [BB_W-1:0]      div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [BLOCK_W-1:0]   res_block_reg, res_block_next;
    logic                 res_end_reg, res_end_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [BLOCK_W-1:0]   m_block_reg;
    logic                 m_end_reg;
    logic [CNT_W-1:0]     m_free_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WW-1:0]        ram_rdata;
    logic                 rd_used;
    logic [LW-1:0]        rd_link;

    logic [CMD_W-1:0]     in_cmd;
    logic                 in_is_end;
    logic [BYTES_W-1:0]   in_bytes;
    logic [BLOCK_W-1:0]   in_block;
    logic [CNT_W-1:0]     eff_n;
    logic [BB_W-1:0]      bb_eff;
    logic                 in_beyond;
    logic                 in_accept;
    logic                 cfg_total_wr;
    logic                 found;
    logic                 scan_issue;
    logic                 link_inside;
    logic                 out_load;
    logic [BB_W:0]        div_trial;
    logic                 div_bit;

    assign in_cmd    = s_tuser[CMD_W-1:0];
    assign in_is_end = s_tuser[CMD_W];
    assign in_bytes  = s_tdata[BYTES_W-1:0];
    assign in_block  = s_tdata[BYTES_W +: BLOCK_W];

    assign eff_n = (32'(total_blocks_reg) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : total_blocks_reg;
    assign bb_eff = (block_bytes_reg == '0) ? BB_W'(1) : block_bytes_reg;
    assign in_beyond = CNT_W'(in_block) >= eff_n;
    assign s_tready = (state_reg == FS_IDLE) && !recount_pend_reg;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_total_wr = cfg_we && (cfg_index == REG_TOTAL_BLOCKS);

    assign rd_used = ram_rdata[LW];
    assign rd_link = ram_rdata[LW-1:0];
    assign found = pend_valid_reg && !rd_used;
    assign scan_issue = 32'(scan_reg) < 32'(eff_n);
    assign link_inside = 32'(rd_link) < 32'(eff_n);
    assign out_load = (state_reg == FS_RESP) && (!m_valid_reg || m_tready);

    assign div_trial = {div_rem_reg, div_num_reg[NUM_W-1]};
    assign div_bit = div_trial >= {1'b0, bb_eff};

    fbca_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_BLOCKS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FS_CLEAR: begin
                if (scan_reg == CLEAR_LAST) begin
                    state_next = FS_IDLE;
                end
            end
            FS_IDLE: begin
                if (recount_pend_reg) begin
                    state_next = FS_RECOUNT;
                end else if (s_tvalid) begin
                    unique case (in_cmd)
                        CMD_ALLOC: state_next = FS_DIV;
                        CMD_FREE:  state_next = (in_is_end || in_beyond) ? FS_RESP : FS_FREE_RD;
                        CMD_NEXT:  state_next = (in_is_end || in_beyond) ? FS_RESP : FS_NEXT_RD;
                        default:   state_next = FS_RESP;
                    endcase
                end
            end
            FS_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = FS_DIV_CHECK;
                end
            end
            FS_DIV_CHECK: begin
                if (div_num_reg == '0 || div_num_reg > NUM_W'(free_reg)) begin
                    state_next = FS_RESP;
                end else begin
                    state_next = FS_ALLOC_SCAN;
                end
            end
            FS_ALLOC_SCAN: begin
                if (found && (got_reg + 1'b1 == need_reg)) begin
                    state_next = FS_ALLOC_END;
                end
            end
            FS_ALLOC_END: state_next = FS_RESP;
            FS_FREE_RD:   state_next = FS_FREE_WB;
            FS_FREE_WB:   state_next = link_inside ? FS_FREE_RD : FS_RESP;
            FS_NEXT_RD:   state_next = FS_NEXT_WB;
            FS_NEXT_WB:   state_next = FS_RESP;
            FS_RECOUNT: begin
                if (!recount_pend_reg && !scan_issue && !pend_valid_reg) begin
                    state_next = FS_IDLE;
                end
            end
            FS_RESP: begin
                if (out_load) begin
                    state_next = FS_IDLE;
                end
            end
            default: state_next = FS_CLEAR;
        endcase
    end

    always_comb begin
        recount_pend_next = recount_pend_reg;
        free_next       = free_reg;
        scan_next       = scan_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = scan_reg[AW-1:0];
        got_next        = got_reg;
        need_next       = need_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        have_last_next  = have_last_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        div_num_next    = div_num_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_end_next    = res_end_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = {1'b0, LINK_END};
        ram_raddr       = scan_reg[AW-1:0];

        unique case (state_reg)
            FS_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[AW-1:0];
                scan_next = scan_reg + 1'b1;
                if (scan_reg == CLEAR_LAST) begin
                    free_next = eff_n;
                end
            end
            FS_IDLE: begin
                if (recount_pend_reg) begin
                    recount_pend_next = 1'b0;
                    scan_next  = '0;
                    count_next = '0;
                end else if (in_accept) begin
                    res_status_next = ((in_cmd == CMD_FREE || in_cmd == CMD_NEXT) && !in_is_end
                                       && in_beyond) ? STAT_RANGE : STAT_OK;
                    res_block_next  = '0;
                    res_end_next    = 1'b1;
                    cur_next        = AW'(in_block);
                    div_num_next    = NUM_W'(in_bytes) + NUM_W'(bb_eff) - NUM_W'(1);
                    div_rem_next    = '0;
                    div_cnt_next    = DIV_CNT_W'(NUM_W - 1);
                end
            end
            FS_DIV: begin
                div_rem_next = div_bit ? BB_W'(div_trial - {1'b0, bb_eff}) : div_trial[BB_W-1:0];
                div_num_next = {div_num_reg[NUM_W-2:0], div_bit};
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            FS_DIV_CHECK: begin
                need_next      = CNT_W'(div_num_reg);
                scan_next      = '0;
                got_next       = '0;
                have_last_next = 1'b0;
                if (div_num_reg != '0 && div_num_reg > NUM_W'(free_reg)) begin
                    res_status_next = STAT_NOSPACE;
                end
            end
            FS_ALLOC_SCAN: begin
                scan_next       = scan_reg + 1'b1;
                pend_valid_next = 1'b1;
                if (found) begin
                    got_next       = got_reg + 1'b1;
                    last_next      = pend_addr_reg;
                    have_last_next = 1'b1;
                    if (!have_last_reg) begin
                        first_next = pend_addr_reg;
                    end
                    ram_we    = have_last_reg;
                    ram_waddr = last_reg;
                    ram_wdata = {1'b1, LW'(pend_addr_reg)};
                end
            end
            FS_ALLOC_END: begin
                ram_we         = 1'b1;
                ram_waddr      = last_reg;
                ram_wdata      = {1'b1, LINK_END};
                free_next      = free_reg - need_reg;
                res_block_next = BLOCK_W'(first_reg);
                res_end_next   = 1'b0;
            end
            FS_FREE_RD: begin
                ram_raddr = cur_reg;
            end
            FS_FREE_WB: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = {1'b0, LINK_END};
                if (rd_used) begin
                    free_next = free_reg + 1'b1;
                end
                cur_next = rd_link[AW-1:0];
            end
            FS_NEXT_RD: begin
                ram_raddr = cur_reg;
            end
            FS_NEXT_WB: begin
                if (rd_link != LINK_END) begin
                    res_block_next = BLOCK_W'(rd_link);
                    res_end_next   = 1'b0;
                end
            end
            FS_RECOUNT: begin
                if (recount_pend_reg) begin
                    recount_pend_next = 1'b0;
                    scan_next  = '0;
                    count_next = '0;
                end else begin
                    pend_valid_next = scan_issue;
                    if (scan_issue) begin
                        scan_next = scan_reg + 1'b1;
                    end
                    if (found) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (!scan_issue && !pend_valid_reg) begin
                        free_next = count_reg;
                    end
                end
            end
            FS_RESP: begin
            end
            default: begin
            end
        endcase

        if (cfg_total_wr) begin
            recount_pend_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= FS_CLEAR;
            block_bytes_reg  <= BLOCK_BYTES_RST;
            total_blocks_reg <= TOTAL_BLOCKS_RST;
            recount_pend_reg <= 1'b0;
            free_reg         <= '0;
            scan_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            recount_pend_reg <= recount_pend_next;
            free_reg         <= free_next;
            scan_reg         <= scan_next;
            pend_valid_reg   <= pend_valid_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_we && cfg_index == REG_BLOCK_BYTES) begin
                block_bytes_reg <= cfg_wdata[BB_W-1:0];
            end
            if (cfg_total_wr) begin
                total_blocks_reg <= cfg_wdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg  <= pend_addr_next;
        got_reg        <= got_next;
        need_reg       <= need_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        have_last_reg  <= have_last_next;
        cur_reg        <= cur_next;
        count_reg      <= count_next;
        div_num_reg    <= div_num_next;
        div_rem_reg    <= div_rem_next;
        div_cnt_reg    <= div_cnt_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_end_reg    <= res_end_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_block_reg  <= res_block_reg;
            m_end_reg    <= res_end_reg;
            m_free_reg   <= free_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {PAD_W'(0), m_free_reg, m_block_reg};
    assign m_tuser  = {m_end_reg, m_status_reg};

    a_free_le_n: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FS_IDLE && !recount_pend_reg) |-> (free_reg <= eff_n))
        else $error("free count exceeds effective block count");

    a_scan_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FS_ALLOC_SCAN && ram_we) |-> (ram_waddr != ram_raddr))
        else $error("link write collides with scan read");

    a_got_below_need: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FS_ALLOC_SCAN) |-> (got_reg < need_reg))
        else $error("allocation took more blocks than needed");

    a_resp_once: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == FS_IDLE && m_valid_reg))
        else $error("result beat not presented after load");

endmodule
